>>> rtl/pcr_pkg.sv
// Shared types and constants for the palette colour ramp.
// No dependencies; used by palette_colour_ramp and its checker.
`default_nettype none

package pcr_pkg;

	// How the result of one word is formed
	typedef enum logic [1:0] {
		MODE_LERP  = 2'd0,
		MODE_WHITE = 2'd1,
		MODE_BLUE  = 2'd2,
		MODE_ZERO  = 2'd3
	} mode_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 3'd0;

	// Entry packing: key 8.8 in [39:24], red [23:16], green [15:8], blue [7:0]
	localparam int KEY_LSB = 24;
	localparam int KEY_MSB = 39;

	localparam logic [23:0] COLOR_DARK_BLUE = 24'h000050;
	localparam logic [23:0] COLOR_WHITE     = 24'hFFFFFF;
	localparam logic [23:0] COLOR_BLACK     = 24'h000000;
	localparam logic [7:0]  KEY_END         = 8'd255;

	localparam logic signed [16:0] FULL_SCALE = 17'sd65280;

endpackage

`default_nettype wire

>>> rtl/palette_colour_ramp.sv
// Piecewise linear colour map: scalar 8.8 value to RGB through a small palette.
// Uses pcr_pkg for the result mode, entry packing and colour constants.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets the
//    number of palette entries in use, index 1..7 write entries 0..6. cfg_ready is
//    always high; write only while no word is in flight.
//  - Input channel (in_valid/in_ready, value_fixed) and output channel
//    (out_valid/out_ready, red, green, blue, zero_span) are valid/ready.
//  - Six register stages: value register, palette scan, differences and
//    reciprocal lookup, channel products, reciprocal multiply, final add.
//    out_valid rises once the word reaches the final-add register; one word per
//    cycle while out_ready does not stall the pipe.
//  - Division by the key span is an exact multiply by a 33-bit reciprocal taken
//    from a 256-entry constant table.
//  - A stall on the output only holds the stages that are full; empty stages
//    keep taking words, so in_ready stays high until the whole pipe is full.
//  - Reset clears all valid bits and the palette registers to zero.
`default_nettype none

module palette_colour_ramp #(
	parameter int PALETTE_ENTRIES = 7
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [pcr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pcr_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic signed [16:0]                  value_fixed,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic [7:0]                          red,
	output      logic [7:0]                          green,
	output      logic [7:0]                          blue,
	output      logic                                zero_span
);

	// ---------------- configuration registers ----------------
	logic [2:0]  count_q;
	logic [pcr_pkg::CFG_DATA_W-1:0] palette_q [PALETTE_ENTRIES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < PALETTE_ENTRIES; i++) palette_q[i] <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == pcr_pkg::CFG_COUNT) count_q <= cfg_data[2:0];
			for (int i = 0; i < PALETTE_ENTRIES; i++) begin
				if (cfg_index == pcr_pkg::CFG_IDX_W'(i + 1)) palette_q[i] <= cfg_data;
			end
		end
	end

	// ---------------- reciprocal table: ceil(2^32 / d) ----------------
	logic [32:0] recip_tab [256];
	assign recip_tab[0] = '0;
	for (genvar gd = 1; gd < 256; gd++) begin : g_recip
		localparam logic [33:0] RECIP_VAL = ((34'd1 << 32) + 34'(gd) - 34'd1) / 34'(gd);
		assign recip_tab[gd] = RECIP_VAL[32:0];
	end

	// ---------------- stage handshake ----------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6 = !vld_s6 || out_ready;
	assign rdy5 = !vld_s5 || rdy6;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
		end
	end

	// ---------------- s1: value and saturated ends ----------------
	logic signed [16:0] v_s1;
	pcr_pkg::mode_t     mode_s1;
	pcr_pkg::mode_t     mode_in;

	always_comb begin
		if (value_fixed >= pcr_pkg::FULL_SCALE) mode_in = pcr_pkg::MODE_BLUE;
		else if (value_fixed <= 17'sd0)         mode_in = pcr_pkg::MODE_WHITE;
		else                                    mode_in = pcr_pkg::MODE_LERP;
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			v_s1    <= value_fixed;
			mode_s1 <= mode_in;
		end
	end

	// ---------------- s2: palette scan ----------------
	logic           found;
	logic [7:0]     pk_c, nk_c;
	logic [23:0]    pc_c, nc_c;
	pcr_pkg::mode_t mode_c2;

	always_comb begin
		found = 1'b0;
		pk_c  = pcr_pkg::KEY_END;
		nk_c  = pcr_pkg::KEY_END;
		pc_c  = pcr_pkg::COLOR_DARK_BLUE;
		nc_c  = pcr_pkg::COLOR_DARK_BLUE;
		// first key above the value is next; the last one not above it is prev
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			if (!found && (3'(i) < count_q)) begin
				if (palette_q[i][pcr_pkg::KEY_MSB:pcr_pkg::KEY_LSB] > v_s1[15:0]) begin
					found = 1'b1;
					nk_c  = palette_q[i][pcr_pkg::KEY_MSB:pcr_pkg::KEY_MSB-7];
					nc_c  = palette_q[i][23:0];
				end else begin
					pk_c  = palette_q[i][pcr_pkg::KEY_MSB:pcr_pkg::KEY_MSB-7];
					pc_c  = palette_q[i][23:0];
				end
			end
		end
		mode_c2 = mode_s1;
		if (mode_s1 == pcr_pkg::MODE_LERP && pk_c == nk_c) mode_c2 = pcr_pkg::MODE_ZERO;
	end

	logic [7:0]     x_s2, pk_s2, nk_s2;
	logic [23:0]    pc_s2, nc_s2;
	pcr_pkg::mode_t mode_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && vld_s1) begin
			x_s2    <= v_s1[15:8];
			pk_s2   <= pk_c;
			nk_s2   <= nk_c;
			pc_s2   <= pc_c;
			nc_s2   <= nc_c;
			mode_s2 <= mode_c2;
		end
	end

	// ---------------- s3: differences, reciprocal lookup ----------------
	logic signed [8:0] den_c;
	logic [7:0]        den_mag;

	assign den_c   = $signed({1'b0, nk_s2}) - $signed({1'b0, pk_s2});
	assign den_mag = den_c[8] ? 8'(-den_c) : den_c[7:0];

	logic signed [8:0] dx_s3;
	logic signed [8:0] dc_s3 [3];
	logic              den_neg_s3;
	logic [32:0]       recip_s3;
	logic [23:0]       cp_s3;
	pcr_pkg::mode_t    mode_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && vld_s2) begin
			dx_s3 <= $signed({1'b0, x_s2}) - $signed({1'b0, pk_s2});
			for (int c = 0; c < 3; c++) begin
				dc_s3[c] <= $signed({1'b0, nc_s2[c*8 +: 8]}) - $signed({1'b0, pc_s2[c*8 +: 8]});
			end
			den_neg_s3 <= den_c[8];
			recip_s3   <= recip_tab[den_mag];
			cp_s3      <= pc_s2;
			mode_s3    <= mode_s2;
		end
	end

	// ---------------- s4: channel products (magnitude and sign) ----------------
	logic [7:0] dx_mag;
	logic [7:0] dc_mag [3];

	assign dx_mag = dx_s3[8] ? 8'(-dx_s3) : dx_s3[7:0];
	always_comb begin
		for (int c = 0; c < 3; c++) dc_mag[c] = dc_s3[c][8] ? 8'(-dc_s3[c]) : dc_s3[c][7:0];
	end

	logic [15:0]    prod_s4 [3];
	logic [2:0]     neg_s4;
	logic [32:0]    recip_s4;
	logic [23:0]    cp_s4;
	pcr_pkg::mode_t mode_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && vld_s3) begin
			for (int c = 0; c < 3; c++) begin
				prod_s4[c] <= 16'(dx_mag) * 16'(dc_mag[c]);
				neg_s4[c]  <= dx_s3[8] ^ dc_s3[c][8] ^ den_neg_s3;
			end
			recip_s4 <= recip_s3;
			cp_s4    <= cp_s3;
			mode_s4  <= mode_s3;
		end
	end

	// ---------------- s5: quotient by reciprocal multiply ----------------
	// Exact for numerators below 2^16 and spans up to 255.
	logic [48:0] full_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) full_c[c] = 49'(prod_s4[c]) * 49'(recip_s4);
	end

	logic [15:0]    q_s5 [3];
	logic [2:0]     neg_s5;
	logic [23:0]    cp_s5;
	pcr_pkg::mode_t mode_s5;

	always_ff @(posedge clk) begin
		if (rdy5 && vld_s4) begin
			for (int c = 0; c < 3; c++) q_s5[c] <= full_c[c][47:32];
			neg_s5  <= neg_s4;
			cp_s5   <= cp_s4;
			mode_s5 <= mode_s4;
		end
	end

	// ---------------- s6: signed quotient plus prev colour, wrap ----------------
	logic [23:0] lerp_c;
	logic [23:0] rgb_c;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			lerp_c[c*8 +: 8] = cp_s5[c*8 +: 8] + (neg_s5[c] ? 8'(-q_s5[c][7:0]) : q_s5[c][7:0]);
		end
		case (mode_s5)
			pcr_pkg::MODE_WHITE: rgb_c = pcr_pkg::COLOR_WHITE;
			pcr_pkg::MODE_BLUE:  rgb_c = pcr_pkg::COLOR_DARK_BLUE;
			pcr_pkg::MODE_ZERO:  rgb_c = pcr_pkg::COLOR_BLACK;
			default:             rgb_c = lerp_c;
		endcase
	end

	logic [23:0] rgb_s6;
	logic        zero_s6;

	always_ff @(posedge clk) begin
		if (rdy6 && vld_s5) begin
			rgb_s6  <= rgb_c;
			zero_s6 <= (mode_s5 == pcr_pkg::MODE_ZERO);
		end
	end

	assign out_valid = vld_s6;
	assign red       = rgb_s6[23:16];
	assign green     = rgb_s6[15:8];
	assign blue      = rgb_s6[7:0];
	assign zero_span = zero_s6;

endmodule

`default_nettype wire

>>> rtl/pcr_check.sv
// Port-level checks for palette_colour_ramp, attached with a bind.
// Depends on the top level's port list and on pcr_pkg.
`default_nettype none

module pcr_check (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                cfg_valid,
	input wire logic                                cfg_ready,
	input wire logic [pcr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input wire logic [pcr_pkg::CFG_DATA_W-1:0]      cfg_data,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic signed [16:0]                  value_fixed,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic [7:0]                          red,
	input wire logic [7:0]                          green,
	input wire logic [7:0]                          blue,
	input wire logic                                zero_span
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({red, green, blue, zero_span}))
		else $error("output word changed while stalled");

	// a zero span always comes out black
	a_zero_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_span |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("zero span word is not black");

	// with the last stage free or draining, the pipe must take a new word
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled while pipe can move");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind palette_colour_ramp pcr_check u_pcr_check (.*);

`default_nettype wire

>>> bench/palette_colour_ramp_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for palette_colour_ramp: directed palettes, random palettes, output stalls.
// Needs pcr_pkg and palette_colour_ramp; colours are predicted from a local copy of the palette.

module palette_colour_ramp_tb;

	localparam int PALETTE_ENTRIES = 7;
	localparam logic [pcr_pkg::CFG_IDX_W-1:0] CFG_ENTRY_BASE = 3'd1;
	localparam int STALL_CYCLES = 150;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 40;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       zero_span;
	} colour_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [pcr_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
	logic [pcr_pkg::CFG_DATA_W-1:0]       cfg_data = '0;
	logic                                 in_valid = 1'b0;
	logic                                 in_ready;
	logic signed [16:0]                   value_fixed = '0;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	logic [7:0]                           red;
	logic [7:0]                           green;
	logic [7:0]                           blue;
	logic                                 zero_span;

	// local copy of the block's registers
	logic [2:0]  pal_count = '0;
	logic [39:0] pal_entry [PALETTE_ENTRIES];
	logic [39:0] palette_stage [PALETTE_ENTRIES];

	colour_t expected_colours [$];
	int      errors = 0;
	bit      no_idle = 1'b0;
	int      stall_serial = 0;
	int      stall_seen = 0;
	int      stall_left = 0;

	palette_colour_ramp #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value_fixed(value_fixed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.zero_span(zero_span)
	);

	always #1 clk = ~clk;

	function automatic logic [7:0] lerp_channel(longint x, longint kp, longint kn,
			longint cp, longint cn);
		longint r;
		// longint division truncates toward zero
		r = (x - kp) * (cn - cp) / (kn - kp) + cp;
		return r[7:0];
	endfunction

	function automatic colour_t map_value(logic signed [16:0] v);
		longint      val;
		longint      key;
		longint      kp;
		longint      kn;
		longint      x;
		logic [39:0] prev_e;
		logic [39:0] next_e;
		int          n;
		bit          found;
		colour_t     c;
		val = v;
		c = '0;
		if (val >= pcr_pkg::FULL_SCALE) begin
			{c.red, c.green, c.blue} = pcr_pkg::COLOR_DARK_BLUE;
			return c;
		end
		if (val <= 0) begin
			{c.red, c.green, c.blue} = pcr_pkg::COLOR_WHITE;
			return c;
		end
		// missing neighbour: key 255, dark blue
		prev_e = {16'd0, pcr_pkg::COLOR_DARK_BLUE};
		next_e = prev_e;
		kp = pcr_pkg::KEY_END;
		kn = pcr_pkg::KEY_END;
		n = (pal_count > PALETTE_ENTRIES) ? PALETTE_ENTRIES : pal_count;
		found = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (!found) begin
				key = pal_entry[i][pcr_pkg::KEY_MSB:pcr_pkg::KEY_LSB];
				if (key > val) begin
					next_e = pal_entry[i];
					kn = key >> 8;
					found = 1'b1;
				end else begin
					prev_e = pal_entry[i];
					kp = key >> 8;
				end
			end
		end
		if (kn == kp) begin
			{c.red, c.green, c.blue} = pcr_pkg::COLOR_BLACK;
			c.zero_span = 1'b1;
			return c;
		end
		x = val >> 8;
		c.red   = lerp_channel(x, kp, kn, prev_e[23:16], next_e[23:16]);
		c.green = lerp_channel(x, kp, kn, prev_e[15:8], next_e[15:8]);
		c.blue  = lerp_channel(x, kp, kn, prev_e[7:0], next_e[7:0]);
		return c;
	endfunction

	// Receiver: random idling, or a counted hold-off when one is requested.
	always @(posedge clk) begin
		if (stall_serial != stall_seen) begin
			stall_seen = stall_serial;
			stall_left = STALL_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(99) >= 25);
		end
	end

	always @(posedge clk) begin
		colour_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_colours.size() == 0) begin
				$error("unexpected output word: %0d %0d %0d %0d", red, green, blue, zero_span);
				errors++;
			end else begin
				want = expected_colours.pop_front();
				if (red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, red);
					errors++;
				end
				if (green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, green);
					errors++;
				end
				if (blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, blue);
					errors++;
				end
				if (zero_span !== want.zero_span) begin
					$error("zero_span: expected %0d, got %0d", want.zero_span, zero_span);
					errors++;
				end
			end
		end
	end

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_colours.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes the count and all seven entries from palette_stage.
	task automatic load_palette(input logic [2:0] count);
		wait_idle();
		for (int i = 0; i <= PALETTE_ENTRIES; i++) begin
			cfg_valid <= 1'b1;
			if (i == 0) begin
				cfg_index <= pcr_pkg::CFG_COUNT;
				cfg_data <= {37'd0, count};
			end else begin
				cfg_index <= CFG_ENTRY_BASE + 3'(i - 1);
				cfg_data <= palette_stage[i - 1];
			end
			do @(posedge clk); while (!cfg_ready);
			if (i == 0)
				pal_count = count;
			else
				pal_entry[i - 1] = palette_stage[i - 1];
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_value(input logic signed [16:0] v);
		in_valid <= 1'b1;
		value_fixed <= v;
		do @(posedge clk); while (!in_ready);
		expected_colours = {expected_colours, map_value(v)};
		if (!no_idle && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	function automatic logic signed [16:0] pick_value();
		int         sel;
		logic [15:0] key;
		sel = $urandom_range(99);
		// land on and around the keys to hit the boundary compares
		if (sel < 20 && pal_count != 0) begin
			key = pal_entry[$urandom_range(pal_count - 1)][pcr_pkg::KEY_MSB:pcr_pkg::KEY_LSB];
			return 17'(int'(key) + int'($urandom_range(4)) - 2);
		end
		if (sel < 75)
			return 17'($urandom_range(65279, 1));
		if (sel < 85)
			return 17'(-int'($urandom_range(65536)));
		if (sel < 93)
			return 17'($urandom_range(65535, 65280));
		return 17'($urandom());
	endfunction

	task automatic random_palette();
		logic [15:0] keys [PALETTE_ENTRIES];
		logic [15:0] t;
		int          style;
		int          d;
		style = $urandom_range(9);
		for (int i = 0; i < PALETTE_ENTRIES; i++)
			keys[i] = 16'($urandom());
		if (style < 8) begin
			for (int i = 0; i < PALETTE_ENTRIES - 1; i++)
				for (int j = 0; j < PALETTE_ENTRIES - 1 - i; j++)
					if (keys[j] > keys[j + 1]) begin
						t = keys[j];
						keys[j] = keys[j + 1];
						keys[j + 1] = t;
					end
		end
		// same integer part on neighbours gives a zero span
		if (style >= 5 && style < 8) begin
			d = $urandom_range(PALETTE_ENTRIES - 2);
			keys[d + 1] = {keys[d][15:8], 8'($urandom())};
		end
		for (int i = 0; i < PALETTE_ENTRIES; i++)
			palette_stage[i] = {keys[i], 24'($urandom())};
		load_palette(3'($urandom_range(7)));
	endtask

	// Count of zero after reset: white, blue, and zero span everywhere between.
	task automatic test_reset_palette();
		send_value(-17'sd65536);
		send_value(-17'sd1);
		send_value(17'sd0);
		send_value(17'sd1);
		send_value(17'sd128);
		send_value(17'sd65279);
		send_value(17'sd65280);
		send_value(17'sd65535);
	endtask

	task automatic test_ordered_ramp();
		palette_stage[0] = {16'h0000, 24'hFF0000};
		palette_stage[1] = {16'h2080, 24'h00FF00};
		palette_stage[2] = {16'h4000, 24'h0000FF};
		palette_stage[3] = {16'h8000, 24'h808080};
		palette_stage[4] = {16'hA0FF, 24'h10E0F0};
		palette_stage[5] = {16'hC000, 24'hFFFFFF};
		palette_stage[6] = {16'hFE00, 24'h000000};
		load_palette(3'd7);
		send_value(17'sh00001);
		send_value(17'sh02080);
		send_value(17'sh0207F);
		send_value(17'sh05000);
		send_value(17'sh0C001);
		send_value(17'sh0FEFF);
		send_value(17'sh0FF00);
	endtask

	// Duplicate integer keys, unordered keys, an all-ones entry, short count.
	task automatic test_span_and_order();
		palette_stage[0] = {16'h1010, 24'h123456};
		palette_stage[1] = {16'h10F0, 24'hABCDEF};
		palette_stage[2] = {16'h0800, 24'h00FF00};
		palette_stage[3] = 40'hFF_FFFF_FFFF;
		palette_stage[4] = {16'h0000, 24'h804020};
		palette_stage[5] = 40'h0;
		palette_stage[6] = 40'h0;
		load_palette(3'd7);
		send_value(17'sh01080);
		send_value(17'sh00100);
		send_value(17'sh02000);
		send_value(17'sh010F0);
		load_palette(3'd1);
		send_value(17'sh01080);
	endtask

	task automatic test_random_palettes();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_palette();
			for (int k = 0; k < WORDS_PER_PHASE; k++)
				send_value(pick_value());
		end
	endtask

	task automatic test_back_to_back();
		no_idle <= 1'b1;
		for (int k = 0; k < 40; k++)
			send_value(pick_value());
		no_idle <= 1'b0;
	endtask

	// Receiver holds off while words keep coming; the pipe fills and in_ready drops.
	task automatic test_output_stall();
		no_idle <= 1'b1;
		stall_serial <= stall_serial + 1;
		for (int k = 0; k < 30; k++)
			send_value(pick_value());
		no_idle <= 1'b0;
	endtask

	task automatic test_drain_pause();
		for (int k = 0; k < 10; k++)
			send_value(pick_value());
		in_valid <= 1'b0;
		while (expected_colours.size() != 0)
			@(posedge clk);
		for (int k = 0; k < 10; k++)
			send_value(pick_value());
	endtask

	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

	initial begin
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			pal_entry[i] = '0;
			palette_stage[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_palette();
		test_ordered_ramp();
		test_span_and_order();
		test_random_palettes();
		test_back_to_back();
		test_output_stall();
		test_drain_pause();
		wait_idle();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
rtl/pcr_pkg.sv
rtl/palette_colour_ramp.sv
rtl/pcr_check.sv
bench/palette_colour_ramp_tb.sv
